/* design/dns_query_name_encoder_assert.svh */
// Assertion macros shared by the checker of the DNS query name encoder.
// Each macro expects signals named clock and reset in the scope that uses it.
`ifndef DNS_QUERY_NAME_ENCODER_ASSERT_SVH
`define DNS_QUERY_NAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQNE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dqne checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define DQNE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dqne checker: next-cycle property failed");

`endif

/* design/dqne_pkg.sv */
// Shared types, constants and helpers of the DNS query name encoder.
// No dependencies; every other design file but the assertion macros header imports this package.
package dqne_pkg;

   // Field widths fixed by the channel definitions.
   localparam int CHAR_W   = 8;
   localparam int ID_W     = 16;
   localparam int DATA_W   = 16;
   localparam int BC_W     = 2;
   localparam int STATUS_W = 3;
   localparam int PLEN_W   = 10;

   // Default limits, handed to the top level parameters.
   localparam int DEF_MAX_LABEL  = 63;
   localparam int DEF_MAX_NAME   = 255;
   localparam int DEF_MAX_PACKET = 512;

   // Packet layout.
   localparam int HDR_BYTES      = 12;
   localparam int TAIL_BYTES     = 5;
   localparam int HDR_QD_POS     = 4;   // header pair whose low byte is the question count
   localparam logic [CHAR_W-1:0] DOT_CHAR       = 8'h2E;
   localparam logic [CHAR_W-1:0] TAIL_TYPE_POS  = 8'd2;
   localparam logic [CHAR_W-1:0] TAIL_CLASS_POS = 8'd4;

   // Byte count codes of one transaction.
   localparam logic [BC_W-1:0] BC_NONE = 2'd0;
   localparam logic [BC_W-1:0] BC_ONE  = 2'd1;
   localparam logic [BC_W-1:0] BC_TWO  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_EMPTY_NAME  = 3'd1,
      ST_NAME_LONG   = 3'd2,
      ST_EMPTY_LABEL = 3'd3,
      ST_LABEL_LONG  = 3'd4,
      ST_PKT_LARGE   = 3'd5
   } dqne_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_HDR,
      FSM_SEG,
      FSM_ERR
   } dqne_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic emit_hdr;
      logic emit_seg;
      logic emit_err;
   } dqne_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_free;
      logic plan_hdr;
      logic plan_seg;
      logic plan_err;
      logic hdr_last;
      logic seg_last;
      logic burst_seg;
      logic burst_err;
   } dqne_sts_type;

   // Byte of the closing question fields at a given offset: zero root label,
   // type A and class IN.
   function automatic logic [CHAR_W-1:0] tail_byte(input logic [CHAR_W-1:0] pos);
      tail_byte = (pos == TAIL_TYPE_POS || pos == TAIL_CLASS_POS) ? 8'd1 : 8'd0;
   endfunction

endpackage

/* design/dqne_if.sv */
// Valid/ready channel interfaces of the DNS query name encoder.
// Depends on dqne_pkg for the field widths.
interface dqne_req_if;
   import dqne_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] name_char;
   logic              end_of_name;
   logic [ID_W-1:0]   query_id;

   modport source (output valid, name_char, end_of_name, query_id, input ready);
   modport sink   (input valid, name_char, end_of_name, query_id, output ready);
endinterface

interface dqne_rsp_if;
   import dqne_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   out_data;
   logic [BC_W-1:0]     byte_count;
   logic [STATUS_W-1:0] status;
   logic                end_of_packet;
   logic [PLEN_W-1:0]   packet_length;

   modport source (output valid, out_data, byte_count, status, end_of_packet, packet_length,
                   input ready);
   modport sink   (input valid, out_data, byte_count, status, end_of_packet, packet_length,
                   output ready);
endinterface

/* design/dqne_ctrl.sv */
// Controller state machine of the DNS query name encoder.
// Depends on dqne_pkg; drives the datapath through dqne_cmd_type.
module dqne_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dqne_pkg::dqne_sts_type sts,
   output dqne_pkg::dqne_cmd_type cmd
);
   import dqne_pkg::*;

   dqne_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               if (sts.plan_hdr) begin
                  state_in = FSM_HDR;
               end else if (sts.plan_seg) begin
                  state_in = FSM_SEG;
               end else if (sts.plan_err) begin
                  state_in = FSM_ERR;
               end
            end
         end
         FSM_HDR: begin
            if (sts.pipe_free && sts.hdr_last) begin
               if (sts.burst_seg) begin
                  state_in = FSM_SEG;
               end else if (sts.burst_err) begin
                  state_in = FSM_ERR;
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end
         FSM_SEG: begin
            if (sts.pipe_free && sts.seg_last) begin
               state_in = sts.burst_err ? FSM_ERR : FSM_IDLE;
            end
         end
         FSM_ERR: begin
            if (sts.pipe_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         FSM_HDR: begin
            cmd.emit_hdr = sts.pipe_free;
         end
         FSM_SEG: begin
            cmd.emit_seg = sts.pipe_free;
         end
         FSM_ERR: begin
            cmd.emit_err = sts.pipe_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* design/dqne_datapath.sv */
// Datapath of the DNS query name encoder: name bookkeeping, two-bank label
// memory, byte-pair sequencer, read stage and output register. Depends on dqne_pkg.
module dqne_datapath #(
   parameter int MAX_LABEL  = dqne_pkg::DEF_MAX_LABEL,
   parameter int MAX_NAME   = dqne_pkg::DEF_MAX_NAME,
   parameter int MAX_PACKET = dqne_pkg::DEF_MAX_PACKET
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dqne_pkg::dqne_cmd_type        cmd,
   output dqne_pkg::dqne_sts_type        sts,
   input  logic [dqne_pkg::CHAR_W-1:0]   req_name_char,
   input  logic                          req_end_of_name,
   input  logic [dqne_pkg::ID_W-1:0]     req_query_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dqne_pkg::DATA_W-1:0]   rsp_out_data,
   output logic [dqne_pkg::BC_W-1:0]     rsp_byte_count,
   output logic [dqne_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_end_of_packet,
   output logic [dqne_pkg::PLEN_W-1:0]   rsp_packet_length
);
   import dqne_pkg::*;

   localparam int LcW     = $clog2(MAX_LABEL + 1);
   localparam int LenW    = LcW + 1;
   localparam int NcW     = $clog2(MAX_NAME + 2);
   localparam int PktW    = $clog2(MAX_PACKET + 1);
   localparam int PktSumW = PktW + 1;
   localparam int SegW    = $clog2(MAX_LABEL + 8);
   localparam int Depth   = MAX_LABEL / 2 + 1;
   localparam int AW      = (Depth > 1) ? $clog2(Depth) : 1;

   // Name state.
   logic [LcW-1:0]  label_count_ff, label_count_in;
   logic [NcW-1:0]  name_count_ff, name_count_in;
   logic            header_sent_ff, header_sent_in;
   logic            pend_ff, pend_in;
   dqne_status_type error_ff, error_in;
   logic [PktW-1:0] packet_ff, packet_in;

   // Label memory: even and odd byte positions of the label segment, where
   // position zero is the length byte and character i sits at position i + 1.
   logic [CHAR_W-1:0] even_mem [Depth];
   logic [CHAR_W-1:0] odd_mem  [Depth];
   logic [LenW-1:0]   wr_pos;

   // Step evaluation.
   dqne_status_type    st_err;
   logic [NcW-1:0]     st_nc;
   logic [LcW-1:0]     st_lc;
   logic               st_pend;
   logic [PktW-1:0]    st_pc;
   logic               close_req, close_ok, tail_go, wr_go;
   logic [LcW-1:0]     close_len;
   logic [PktSumW-1:0] close_sum;
   logic [LenW-1:0]    lab_len_c;
   logic [SegW-1:0]    seg_len_c;

   // Burst plan, loaded when an item is accepted.
   logic [ID_W-1:0]   id_ff;
   logic [LenW-1:0]   lablen_ff;
   logic [CHAR_W-1:0] labbyte_ff;
   logic [SegW-1:0]   seglen_ff;
   logic              eop_ok_ff;
   logic              err_final_ff;
   dqne_status_type   code_ff;
   logic [PktW-1:0]   pktlen_ff;
   logic [SegW-1:0]   q_ff, q_in;

   // Sequencer output toward the read stage.
   logic [SegW-1:0]     q1, t_hi, t_lo;
   logic                emit;
   logic [CHAR_W-1:0]   s_hi_byte, s_lo_byte;
   logic                s_hi_mem, s_lo_mem;
   logic [BC_W-1:0]     s_bc;
   dqne_status_type     s_status;
   logic                s_eop;
   logic [PktW-1:0]     s_plen;

   // Read stage.
   logic                p_valid_ff;
   logic [CHAR_W-1:0]   p_hi_byte_ff, p_lo_byte_ff, rd_even_ff, rd_odd_ff;
   logic                p_hi_mem_ff, p_lo_mem_ff;
   logic [BC_W-1:0]     p_bc_ff;
   dqne_status_type     p_status_ff;
   logic                p_eop_ff;
   logic [PktW-1:0]     p_plen_ff;

   // Output register.
   logic                o_valid_ff;
   logic [DATA_W-1:0]   o_data_ff;
   logic [BC_W-1:0]     o_bc_ff;
   dqne_status_type     o_status_ff;
   logic                o_eop_ff;
   logic [PLEN_W-1:0]   o_plen_ff;
   logic                o_free, p_move;

   // ---------------------------------------------------------------------
   // Evaluate one character against the name state.
   always_comb begin
      st_err    = error_ff;
      st_nc     = name_count_ff;
      st_lc     = label_count_ff;
      st_pend   = pend_ff;
      st_pc     = header_sent_ff ? packet_ff : PktW'(HDR_BYTES);
      close_req = 1'b0;
      close_ok  = 1'b0;
      tail_go   = 1'b0;
      wr_go     = 1'b0;
      close_len = '0;
      close_sum = '0;
      if (st_err == ST_OK) begin
         if (st_nc <= NcW'(MAX_NAME)) begin
            st_nc = st_nc + 1'b1;
         end
         if (st_nc > NcW'(MAX_NAME)) begin
            st_err = ST_NAME_LONG;
         end
      end
      if (st_err == ST_OK) begin
         if (req_name_char == DOT_CHAR) begin
            if (st_lc == '0) begin
               st_pend = 1'b1;
            end else begin
               close_req = 1'b1;
            end
         end else if (st_pend) begin
            st_err = ST_EMPTY_LABEL;
         end else if (st_lc >= LcW'(MAX_LABEL)) begin
            st_err = ST_LABEL_LONG;
         end else begin
            wr_go     = 1'b1;
            st_lc     = st_lc + 1'b1;
            close_req = req_end_of_name;
         end
      end
      if (close_req) begin
         close_sum = PktSumW'(st_pc) + PktSumW'(st_lc) + PktSumW'(1 + TAIL_BYTES);
         if (close_sum > PktSumW'(MAX_PACKET)) begin
            st_err = ST_PKT_LARGE;
         end else begin
            close_ok  = 1'b1;
            close_len = st_lc;
            st_pc     = st_pc + PktW'(st_lc) + PktW'(1);
            st_lc     = '0;
         end
      end
      if (req_end_of_name && st_err == ST_OK) begin
         if (st_pc == PktW'(HDR_BYTES)) begin
            st_err = ST_EMPTY_NAME;
         end else begin
            tail_go = 1'b1;
            st_pc   = st_pc + PktW'(TAIL_BYTES);
         end
      end
      lab_len_c = close_ok ? (LenW'(close_len) + 1'b1) : '0;
      seg_len_c = SegW'(lab_len_c) + (tail_go ? SegW'(TAIL_BYTES) : '0);
   end

   // The end of a name returns every piece of name state to zero.
   always_comb begin
      label_count_in = label_count_ff;
      name_count_in  = name_count_ff;
      header_sent_in = header_sent_ff;
      pend_in        = pend_ff;
      error_in       = error_ff;
      packet_in      = packet_ff;
      if (cmd.accept) begin
         if (req_end_of_name) begin
            label_count_in = '0;
            name_count_in  = '0;
            header_sent_in = 1'b0;
            pend_in        = 1'b0;
            error_in       = ST_OK;
            packet_in      = '0;
         end else begin
            label_count_in = st_lc;
            name_count_in  = st_nc;
            header_sent_in = 1'b1;
            pend_in        = st_pend;
            error_in       = st_err;
            packet_in      = st_pc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_count_ff <= '0;
         name_count_ff  <= '0;
         header_sent_ff <= 1'b0;
         pend_ff        <= 1'b0;
         error_ff       <= ST_OK;
         packet_ff      <= '0;
      end else begin
         label_count_ff <= label_count_in;
         name_count_ff  <= name_count_in;
         header_sent_ff <= header_sent_in;
         pend_ff        <= pend_in;
         error_ff       <= error_in;
         packet_ff      <= packet_in;
      end
   end

   assign wr_pos = LenW'(label_count_ff) + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_go) begin
         if (wr_pos[0]) begin
            odd_mem[wr_pos[AW:1]] <= req_name_char;
         end else begin
            even_mem[wr_pos[AW:1]] <= req_name_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         id_ff        <= req_query_id;
         lablen_ff    <= lab_len_c;
         labbyte_ff   <= CHAR_W'(close_len);
         seglen_ff    <= seg_len_c;
         eop_ok_ff    <= tail_go;
         err_final_ff <= req_end_of_name && (st_err != ST_OK);
         code_ff      <= st_err;
         pktlen_ff    <= st_pc;
      end
   end

   // ---------------------------------------------------------------------
   // Pair sequencer: q_ff is the position of the upper byte of the next pair.
   always_comb begin
      q_in = q_ff;
      if (cmd.accept) begin
         q_in = '0;
      end else if (cmd.emit_hdr) begin
         q_in = sts.hdr_last ? '0 : q_ff + SegW'(2);
      end else if (cmd.emit_seg) begin
         q_in = q_ff + SegW'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q1   = q_ff + 1'b1;
   assign t_hi = q_ff - SegW'(lablen_ff);
   assign t_lo = q1 - SegW'(lablen_ff);
   assign emit = cmd.emit_hdr | cmd.emit_seg | cmd.emit_err;

   always_comb begin
      s_hi_byte = '0;
      s_lo_byte = '0;
      s_hi_mem  = 1'b0;
      s_lo_mem  = 1'b0;
      s_bc      = BC_TWO;
      s_status  = ST_OK;
      s_eop     = 1'b0;
      s_plen    = '0;
      if (cmd.emit_hdr) begin
         if (q_ff == '0) begin
            s_hi_byte = id_ff[ID_W-1 -: CHAR_W];
            s_lo_byte = id_ff[CHAR_W-1:0];
         end else if (q_ff == SegW'(HDR_QD_POS)) begin
            s_lo_byte = 8'd1;
         end
      end else if (cmd.emit_seg) begin
         if (q_ff < SegW'(lablen_ff)) begin
            s_hi_mem  = (q_ff != '0);
            s_hi_byte = labbyte_ff;
         end else begin
            s_hi_byte = tail_byte(CHAR_W'(t_hi));
         end
         if (q1 < seglen_ff) begin
            if (q1 < SegW'(lablen_ff)) begin
               s_lo_mem = 1'b1;
            end else begin
               s_lo_byte = tail_byte(CHAR_W'(t_lo));
            end
         end else begin
            s_bc = BC_ONE;
         end
         if (sts.seg_last && eop_ok_ff) begin
            s_eop  = 1'b1;
            s_plen = pktlen_ff;
         end
      end else if (cmd.emit_err) begin
         s_bc     = BC_NONE;
         s_status = code_ff;
         s_eop    = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Read stage and output register.
   assign o_free = !o_valid_ff || rsp_ready;
   assign p_move = p_valid_ff && o_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            p_valid_ff <= 1'b1;
         end else if (p_move) begin
            p_valid_ff <= 1'b0;
         end
         if (p_move) begin
            o_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         p_hi_byte_ff <= s_hi_byte;
         p_lo_byte_ff <= s_lo_byte;
         p_hi_mem_ff  <= s_hi_mem;
         p_lo_mem_ff  <= s_lo_mem;
         p_bc_ff      <= s_bc;
         p_status_ff  <= s_status;
         p_eop_ff     <= s_eop;
         p_plen_ff    <= s_plen;
      end
      if (cmd.emit_seg) begin
         rd_even_ff <= even_mem[q_ff[AW:1]];
         rd_odd_ff  <= odd_mem[q_ff[AW:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (p_move) begin
         o_data_ff   <= {(p_hi_mem_ff ? rd_even_ff : p_hi_byte_ff),
                         (p_lo_mem_ff ? rd_odd_ff : p_lo_byte_ff)};
         o_bc_ff     <= p_bc_ff;
         o_status_ff <= p_status_ff;
         o_eop_ff    <= p_eop_ff;
         o_plen_ff   <= PLEN_W'(p_plen_ff);
      end
   end

   // ---------------------------------------------------------------------
   always_comb begin
      sts.pipe_free = !p_valid_ff || p_move;
      sts.plan_hdr  = !header_sent_ff;
      sts.plan_seg  = (seg_len_c != '0);
      sts.plan_err  = req_end_of_name && (st_err != ST_OK);
      sts.hdr_last  = (q_ff == SegW'(HDR_BYTES - 2));
      sts.seg_last  = ((q_ff + SegW'(2)) >= seglen_ff);
      sts.burst_seg = (seglen_ff != '0);
      sts.burst_err = err_final_ff;
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_out_data      = o_data_ff;
   assign rsp_byte_count    = o_bc_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_end_of_packet = o_eop_ff;
   assign rsp_packet_length = o_plen_ff;

endmodule

/* design/dns_query_name_encoder.sv */
// DNS A/IN query encoder: turns a domain name, one character per
// transaction on req_ch, into the query packet, two bytes per transaction on rsp_ch.
//
// The first character of a name produces the 12-byte header (six transactions)
// carrying the query id sampled with it. A dot that closes a label, or the
// character that ends the name, produces the length byte followed by the label
// characters; the end of the name adds the zero root byte, type A and class IN.
// All bytes of one input transaction are packed two per output transaction,
// upper half first; an odd count ends with byte_count one. The last output
// transaction of a good name has end_of_packet set and the packet length. An
// error is held until the end of the name and is then reported in one extra
// transaction with byte_count zero, the status code and end_of_packet set.
//
// Timing: req_ch is ready only while the controller is idle, so a character that
// emits bytes or an error report holds off the next until its last pair has
// entered the read stage. The pair sequencer reads two label bytes a cycle from
// the two-bank label memory while the read stage is free, then each result passes
// through the read stage and the output register. A stalled receiver fills the
// output register and the read stage, then holds the sequencer; nothing is lost.
// Reset is synchronous and clears all name state and both pipeline stages.
module dns_query_name_encoder #(
   parameter int MAX_LABEL  = dqne_pkg::DEF_MAX_LABEL,
   parameter int MAX_NAME   = dqne_pkg::DEF_MAX_NAME,
   parameter int MAX_PACKET = dqne_pkg::DEF_MAX_PACKET
) (
   input  logic       clock,
   input  logic       reset,
   dqne_req_if.sink   req_ch,
   dqne_rsp_if.source rsp_ch
);
   import dqne_pkg::*;

   dqne_cmd_type cmd;
   dqne_sts_type sts;

   // The controller sequences header, label and error phases of one burst.
   dqne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath keeps the name state, the label memory and the output stages.
   dqne_datapath #(
      .MAX_LABEL  (MAX_LABEL),
      .MAX_NAME   (MAX_NAME),
      .MAX_PACKET (MAX_PACKET)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_name_char     (req_ch.name_char),
      .req_end_of_name   (req_ch.end_of_name),
      .req_query_id      (req_ch.query_id),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_out_data      (rsp_ch.out_data),
      .rsp_byte_count    (rsp_ch.byte_count),
      .rsp_status        (rsp_ch.status),
      .rsp_end_of_packet (rsp_ch.end_of_packet),
      .rsp_packet_length (rsp_ch.packet_length)
   );

endmodule

/* design/dqne_checker.sv */
// Port-level checker of the DNS query name encoder, bound to the top level.
// Depends on dqne_pkg and the assertion macros header.
`include "dns_query_name_encoder_assert.svh"

module dqne_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dqne_pkg::DATA_W-1:0]   rsp_out_data,
   input logic [dqne_pkg::BC_W-1:0]     rsp_byte_count,
   input logic [dqne_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_end_of_packet,
   input logic [dqne_pkg::PLEN_W-1:0]   rsp_packet_length
);
   import dqne_pkg::*;

   // A stalled result keeps its bytes and status.
   `DQNE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_data) && $stable(rsp_status))

   // A result without bytes is always an error report that closes the packet.
   `DQNE_ASSERT_SAME(a_empty_is_error, rsp_valid && rsp_byte_count == BC_NONE, rsp_end_of_packet && rsp_status != ST_OK && rsp_out_data == '0)

   // A nonzero status only appears on the closing result.
   `DQNE_ASSERT_SAME(a_status_at_end, rsp_valid && rsp_status != ST_OK, rsp_end_of_packet)

   // A packet length is only reported on a good closing result.
   `DQNE_ASSERT_SAME(a_length_at_end, rsp_valid && rsp_packet_length != '0, rsp_end_of_packet && rsp_status == ST_OK)

endmodule

bind dns_query_name_encoder dqne_checker u_dqne_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_out_data      (rsp_ch.out_data),
   .rsp_byte_count    (rsp_ch.byte_count),
   .rsp_status        (rsp_ch.status),
   .rsp_end_of_packet (rsp_ch.end_of_packet),
   .rsp_packet_length (rsp_ch.packet_length)
);
